### rtl/vrbs_pkg.sv
package vrbs_pkg;

    // Default sizing of the store
    localparam int STACK_BYTES_DEF = 1024;
    localparam int LEN_BYTES_DEF   = 2;
    localparam int MAX_RECORD_DEF  = 64;

    // Fixed field widths
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

    typedef enum logic [2:0] {
        CMD_PUSH,
        CMD_POP,
        CMD_PEEK,
        CMD_CLEAR,
        CMD_QUERY,
        CMD_NOP
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_EMIT,
        S_TRAIL
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  length;
        logic              last_byte;
    } t_item;

    typedef struct packed {
        logic              strobe;
        t_status           status;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last_result;
        logic              is_empty;
        logic              no_room;
    } t_result;

endpackage

### rtl/vrbs_front.sv
module vrbs_front
    import vrbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_length,
    input  logic              i_last_byte,
    output logic              o_valid,
    output t_item             o_item,
    input  logic              i_deq
);

    t_item            r_slot [QDEPTH];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QAW:0]     r_fill;
    logic             enq;
    t_item            item_in;

    function automatic t_cmd classify(input logic [OP_W-1:0] op);
        t_cmd c;
        unique case (op)
            OP_PUSH:  c = CMD_PUSH;
            OP_POP:   c = CMD_POP;
            OP_PEEK:  c = CMD_PEEK;
            OP_CLEAR: c = CMD_CLEAR;
            OP_QUERY: c = CMD_QUERY;
            default:  c = CMD_NOP;
        endcase
        return c;
    endfunction

    assign o_busy  = (r_fill == (QAW+1)'(QDEPTH));
    assign enq     = i_start && !o_busy;
    assign o_valid = (r_fill != '0);
    assign o_item  = r_slot[r_rptr];

    always_comb begin
        item_in.cmd       = classify(i_op);
        item_in.data_byte = i_data_byte;
        item_in.length    = i_length;
        item_in.last_byte = i_last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_slot[r_wptr] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (enq) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_deq) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            r_fill <= r_fill + (QAW+1)'(enq) - (QAW+1)'(i_deq);
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (QAW+1)'(QDEPTH)) else $error("queue overfilled");

    a_deq_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_deq |-> o_valid) else $error("dequeue from empty queue");

endmodule

### rtl/vrbs_back.sv
module vrbs_back
    import vrbs_pkg::*;
#(
    parameter int STACK_BYTES = STACK_BYTES_DEF,
    parameter int LEN_BYTES   = LEN_BYTES_DEF,
    parameter int MAX_RECORD  = MAX_RECORD_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_deq,
    output t_result o_result
);

    localparam int MAW = $clog2(STACK_BYTES);
    localparam int PW  = MAW + 1;
    localparam int RW  = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam int TW  = $clog2(LEN_BYTES + 1);

    logic [BYTE_W-1:0] r_store [STACK_BYTES];
    logic [BYTE_W-1:0] r_rdata;

    t_state            r_state,   n_state;
    logic [PW-1:0]     r_top,     n_top;
    logic              r_in_prog, n_in_prog;
    logic              r_rej,     n_rej;
    logic [LEN_W-1:0]  r_lim,     n_lim;
    logic [LEN_W-1:0]  r_cnt,     n_cnt;
    logic [TW-1:0]     r_tix,     n_tix;
    logic [LEN_W-1:0]  r_want,    n_want;
    logic              r_pop,     n_pop;
    logic [PW-1:0]     r_base,    n_base;
    logic [LEN_W-1:0]  r_n,       n_n;
    logic [LEN_W-1:0]  r_idx,     n_idx;

    logic              r_strobe,  n_strobe;
    t_status           r_status,  n_status;
    logic              r_bv,      n_bv;
    logic              r_last,    n_last;
    logic              r_empty,   n_empty;
    logic              r_noroom,  n_noroom;

    logic              mem_we;
    logic [MAW-1:0]    mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [MAW-1:0]    mem_raddr;

    logic              lacks;
    logic [LEN_W-1:0]  eff_cnt;
    logic [LEN_W-1:0]  eff_lim;
    logic              eff_rej;
    logic              wr_ok;
    logic [LEN_W-1:0]  cnt_new;
    logic [LEN_W-1:0]  stored;
    logic [LEN_W-1:0]  take;
    logic [PW-1:0]     base;
    logic [PW-1:0]     tmp_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_store[mem_raddr];
        end
    end

    assign lacks = (RW'(STACK_BYTES) - RW'(r_top)) < (RW'(i_item.length) + RW'(LEN_BYTES));
    assign o_deq = (r_state == S_IDLE) && i_valid;

    always_comb begin
        n_state   = r_state;
        n_top     = r_top;
        n_in_prog = r_in_prog;
        n_rej     = r_rej;
        n_lim     = r_lim;
        n_cnt     = r_cnt;
        n_tix     = r_tix;
        n_want    = r_want;
        n_pop     = r_pop;
        n_base    = r_base;
        n_n       = r_n;
        n_idx     = r_idx;
        n_strobe  = 1'b0;
        n_status  = ST_OK;
        n_bv      = 1'b0;
        n_last    = 1'b1;
        n_empty   = 1'b0;
        n_noroom  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        eff_cnt   = r_in_prog ? r_cnt : '0;
        eff_lim   = r_in_prog ? r_lim : i_item.length;
        eff_rej   = r_in_prog ? r_rej
                              : ((i_item.length > LEN_W'(MAX_RECORD)) || lacks);
        wr_ok     = !eff_rej && (eff_cnt < eff_lim);
        cnt_new   = eff_cnt + LEN_W'(wr_ok);
        stored    = r_rdata[LEN_W-1:0];
        take      = (r_want < stored) ? r_want : stored;
        base      = r_top - PW'(LEN_BYTES) - PW'(stored);
        tmp_addr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_strobe = 1'b1;
                    unique case (i_item.cmd) inside
                        CMD_PUSH: begin
                            tmp_addr  = r_top + PW'(eff_cnt);
                            mem_we    = wr_ok;
                            mem_waddr = tmp_addr[MAW-1:0];
                            mem_wdata = i_item.data_byte;
                            n_cnt     = cnt_new;
                            if (i_item.last_byte) begin
                                n_in_prog = 1'b0;
                                n_rej     = 1'b0;
                                if (eff_rej) begin
                                    n_status = ST_FULL;
                                end else begin
                                    n_tix   = '0;
                                    n_state = S_TRAIL;
                                end
                            end else begin
                                n_in_prog = 1'b1;
                                n_rej     = eff_rej;
                                n_lim     = eff_lim;
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (i_item.cmd == CMD_POP) begin
                                n_in_prog = 1'b0;
                                n_rej     = 1'b0;
                            end
                            if (r_top == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_strobe  = 1'b0;
                                tmp_addr  = r_top - PW'(LEN_BYTES);
                                mem_re    = 1'b1;
                                mem_raddr = tmp_addr[MAW-1:0];
                                n_want    = i_item.length;
                                n_pop     = (i_item.cmd == CMD_POP);
                                n_state   = S_LEN;
                            end
                        end
                        CMD_CLEAR: begin
                            n_in_prog = 1'b0;
                            n_rej     = 1'b0;
                            n_top     = '0;
                        end
                        CMD_QUERY: begin
                            n_empty  = (r_top == '0);
                            n_noroom = lacks;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LEN: begin
                if (r_pop) begin
                    n_top = base;
                end
                if (take == '0) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_base  = base;
                    n_n     = take;
                    n_idx   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                tmp_addr  = r_base + PW'(r_idx);
                mem_re    = 1'b1;
                mem_raddr = tmp_addr[MAW-1:0];
                n_strobe  = 1'b1;
                n_bv      = 1'b1;
                n_last    = (r_idx == r_n - 1'b1);
                n_idx     = r_idx + 1'b1;
                if (n_last) begin
                    n_state = S_IDLE;
                end
            end
            S_TRAIL: begin
                tmp_addr  = r_top + PW'(r_cnt) + PW'(r_tix);
                mem_we    = 1'b1;
                mem_waddr = tmp_addr[MAW-1:0];
                mem_wdata = (r_tix == '0) ? BYTE_W'(r_cnt) : '0;
                n_tix     = r_tix + 1'b1;
                if (r_tix == TW'(LEN_BYTES - 1)) begin
                    n_top   = r_top + PW'(r_cnt) + PW'(LEN_BYTES);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_top     <= '0;
            r_in_prog <= 1'b0;
            r_rej     <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_in_prog <= n_in_prog;
            r_rej     <= n_rej;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim    <= n_lim;
        r_cnt    <= n_cnt;
        r_tix    <= n_tix;
        r_want   <= n_want;
        r_pop    <= n_pop;
        r_base   <= n_base;
        r_n      <= n_n;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_bv     <= n_bv;
        r_last   <= n_last;
        r_empty  <= n_empty;
        r_noroom <= n_noroom;
    end

    always_comb begin
        o_result.strobe      = r_strobe;
        o_result.status      = r_status;
        o_result.out_byte    = r_bv ? r_rdata : '0;
        o_result.byte_valid  = r_bv;
        o_result.last_result = r_last;
        o_result.is_empty    = r_empty;
        o_result.no_room     = r_noroom;
    end

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= PW'(STACK_BYTES)) else $error("top pointer beyond store");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx < r_n)) else $error("emit index overrun");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_prog && !r_rej) |-> (r_cnt <= r_lim)) else $error("push count past limit");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_strobe && n_bv) |=> (r_status == ST_OK)) else $error("byte result not ok");

endmodule

### rtl/variable_record_byte_stack.sv
// Channel   Handshake                 Payload
// command   start in, busy out        i_op, i_data_byte, i_length, i_last_byte
// result    o_strobe out, no back-off o_status, o_out_byte, o_byte_valid,
//                                     o_last_result, o_is_empty, o_no_room
//
// A two-entry command queue takes one item a cycle while it has room; busy is
// high only when that queue is full.
// Push: the last byte of a kept record is followed by LEN_BYTES trailer
// writes through the single store write port.
// Pop and peek: the trailer is fetched first, then each byte is delivered
// through the registered store read port.
// Reset clears pointers and queue at once; the store is left as it is.
// The receiver cannot stall: each result shows for exactly one cycle.
module variable_record_byte_stack
    import vrbs_pkg::*;
#(
    parameter int STACK_BYTES = STACK_BYTES_DEF,
    parameter int LEN_BYTES   = LEN_BYTES_DEF,
    parameter int MAX_RECORD  = MAX_RECORD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_length,
    input  logic              i_last_byte,
    output logic              o_strobe,
    output logic [1:0]        o_status,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_byte_valid,
    output logic              o_last_result,
    output logic              o_is_empty,
    output logic              o_no_room
);

    // Classified item handed from the front queue to the executing back end
    t_item   q_item;
    logic    q_valid;
    logic    q_deq;
    t_result res;

    // Front: accept and classify each item, hold it in the queue
    vrbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_length    (i_length),
        .i_last_byte (i_last_byte),
        .o_valid     (q_valid),
        .o_item      (q_item),
        .i_deq       (q_deq)
    );

    // Back: run each item against the byte store and drive the results
    vrbs_back #(
        .STACK_BYTES (STACK_BYTES),
        .LEN_BYTES   (LEN_BYTES),
        .MAX_RECORD  (MAX_RECORD)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_deq    (q_deq),
        .o_result (res)
    );

    // Unpack the result bundle onto the ports
    assign o_strobe      = res.strobe;
    assign o_status      = res.status;
    assign o_out_byte    = res.out_byte;
    assign o_byte_valid  = res.byte_valid;
    assign o_last_result = res.last_result;
    assign o_is_empty    = res.is_empty;
    assign o_no_room     = res.no_room;

endmodule
